/* src/triangle_depth_rasterizer_top_assert.svh */
// Assertion macros used by the rasterizer top module.
`ifndef TRIANGLE_DEPTH_RASTERIZER_TOP_ASSERT_SVH
`define TRIANGLE_DEPTH_RASTERIZER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TDR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define TDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/tdr_pkg.sv */
package tdr_pkg;
  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int XyW       = $clog2(MaxWidth);
  localparam int YyW       = $clog2(MaxHeight);
  localparam int AddrW     = XyW + YyW;
  localparam int Depth     = MaxWidth * MaxHeight;
  localparam int ZW        = 24;
  localparam logic [ZW-1:0] DepthInf  = 24'hFFFFFF;
  localparam logic [ZW-1:0] DepthMaxv = 24'hFFFFFE;
  localparam logic [1:0] CmdDraw  = 2'd0;
  localparam logic [1:0] CmdClear = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;
  // no function; answered with zero
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;
endpackage

/* src/tdr_ram.sv */
module tdr_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/tdr_div.sv */
// Restoring divider, one quotient bit per cycle. 64-bit dividend by 48-bit divisor.
module tdr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] q;
  logic [48:0] rem;
  logic [6:0]  cnt;
  logic        run;
  logic [48:0] trial;
  assign trial = {rem[47:0], q[63]} - {1'b0, den};
  assign quo = q;
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 7'd0;
        q <= num;
        rem <= '0;
      end else if (run) begin
        if (!trial[48]) begin
          rem <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[47:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/triangle_depth_rasterizer_top.sv */
// Channel   | Signals                               | Handshake
// command   | start, cmd, v*_x/y/z, read_x, read_y  | start & !busy
// result    | depth_value                           | done strobe, one cycle
// config    | cfg_we, cfg_index, cfg_data           | cfg_we, no wait
// After reset the store is cleared, one pixel a cycle (busy high, no done
//   strobe). A clear request takes the same sweep and ends with done. A read
//   returns the stored depth with done; an unused cmd answers the next cycle.
// A draw computes the area in setup, then walks its clipped box: edge tests
//   on the shared multiplier for each pixel, plus for a covered pixel
//   6 depth products, a serial division and a compare.
// Reset: rst is synchronous, active high. The receiver cannot stall.
module triangle_depth_rasterizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  cmd,
  input  logic signed [15:0] v0_x, v0_y, v1_x, v1_y, v2_x, v2_y,
  input  logic [23:0] v0_z, v1_z, v2_z,
  input  logic signed [11:0] read_x, read_y,
  output logic [23:0] depth_value,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import tdr_pkg::*;
  `include "triangle_depth_rasterizer_top_assert.svh"

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_SETUP = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_TEST  = 11'b00000010000,
    S_ZMUL  = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_RDWT  = 11'b00010000000,
    S_CMP   = 11'b00100000000,
    S_NEXT  = 11'b01000000000,
    S_READ  = 11'b10000000000
  } state_t;

  state_t state;
  // set by reset: the power-up clear sends no done strobe
  logic init_clr;
  logic [9:0] screen_width, screen_height;
  logic [10:0] eff_w, eff_h;
  assign eff_w = (screen_width > 10'(MaxWidth)) ? 11'(MaxWidth) : {1'b0, screen_width};
  assign eff_h = (screen_height > 10'(MaxHeight)) ? 11'(MaxHeight) : {1'b0, screen_height};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 10'(MaxWidth);
      screen_height <= 10'(MaxHeight);
    end else if (cfg_we) begin
      case (cfg_index)
        RegWidth:  screen_width <= cfg_data;
        RegHeight: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic signed [17:0] x0, y0, x1, y1, x2, y2;
  logic [23:0] z0, z1, z2;
  logic signed [13:0] minx, maxx, miny, maxy, px, py;
  logic signed [36:0] area;
  logic signed [36:0] e0, e1, e2;
  logic [63:0] acc;
  logic [3:0] step;
  logic [AddrW-1:0] addr_cnt;
  logic [AddrW-1:0] waddr, raddr;
  logic we;
  logic [23:0] wdata, rdata, dnew;

  // Bounds from vertex input (combinational, at accept).
  function automatic logic signed [13:0] fl16(input logic signed [15:0] v);
    return 14'(v >>> 4);
  endfunction
  logic signed [15:0] mnx, mxx, mny, mxy;
  always_comb begin
    mnx = v0_x; if (v1_x < mnx) mnx = v1_x; if (v2_x < mnx) mnx = v2_x;
    mxx = v0_x; if (v1_x > mxx) mxx = v1_x; if (v2_x > mxx) mxx = v2_x;
    mny = v0_y; if (v1_y < mny) mny = v1_y; if (v2_y < mny) mny = v2_y;
    mxy = v0_y; if (v1_y > mxy) mxy = v1_y; if (v2_y > mxy) mxy = v2_y;
  end
  logic signed [16:0] ce_mxx, ce_mxy;
  assign ce_mxx = (17'(mxx) + 17'sd15) >>> 4;
  assign ce_mxy = (17'(mxy) + 17'sd15) >>> 4;

  // Shared multiplier, 19x25 signed: edge products, or an 18-bit half of a
  // weight magnitude times a vertex depth.
  logic signed [18:0] ma;
  logic signed [24:0] mb;
  logic signed [43:0] mp;
  assign mp = ma * mb;
  logic [35:0] mag;
  logic [23:0] mz;
  logic [17:0] mhalf;
  logic [41:0] zp;
  assign zp = 42'(mp);

  logic signed [17:0] cx, cy;
  assign cx = 18'(px) * 18'sd16 + 18'sd8;
  assign cy = 18'(py) * 18'sd16 + 18'sd8;
  logic signed [36:0] t1;

  logic div_go, div_done;
  logic [63:0] quo;
  logic [47:0] aabs;
  assign aabs = 48'(area[36] ? -area : area);
  tdr_div u_div (.clk, .rst, .go(div_go), .num(acc), .den(aabs),
                 .done(div_done), .quo);

  tdr_ram #(.Width(ZW), .Depth(Depth)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata);

  // Pixel address, row stride is the active width.
  logic [AddrW-1:0] idx;
  assign idx = AddrW'(py) * AddrW'(eff_w) + AddrW'(px);
  logic rd_ok;
  assign rd_ok = !read_x[11] && !read_y[11] && (13'(read_x) < 13'(eff_w))
                 && (13'(read_y) < 13'(eff_h));
  logic rd_skip;

  // Multiply operand selection.
  always_comb begin
    ma = '0; mb = '0;
    if (state == S_ZMUL) begin
      ma = $signed({1'b0, mhalf});
      mb = $signed({1'b0, mz});
    end else begin
      case (step)
        4'd0: begin ma = 19'(x2 - x0); mb = 25'(y1 - y0); end
        4'd1: begin ma = 19'(y2 - y0); mb = 25'(x1 - x0); end
        4'd2: begin ma = 19'(cx - x1); mb = 25'(y2 - y1); end
        4'd3: begin ma = 19'(cy - y1); mb = 25'(x2 - x1); end
        4'd4: begin ma = 19'(cx - x2); mb = 25'(y0 - y2); end
        4'd5: begin ma = 19'(cy - y2); mb = 25'(x0 - x2); end
        4'd6: begin ma = 19'(cx - x0); mb = 25'(y1 - y0); end
        4'd7: begin ma = 19'(cy - y0); mb = 25'(x1 - x0); end
        default: ;
      endcase
    end
  end
  always_comb begin
    mag = '0; mz = z0;
    case (step[2:1])
      2'd0: begin mag = 36'(e0[36] ? -e0 : e0); mz = z0; end
      2'd1: begin mag = 36'(e1[36] ? -e1 : e1); mz = z1; end
      2'd2: begin mag = 36'(e2[36] ? -e2 : e2); mz = z2; end
      default: ;
    endcase
    mhalf = step[0] ? mag[35:18] : mag[17:0];
  end

  // Zero weight counts as covered, either winding.
  logic covered;
  assign covered = area[36] ? (e0 <= 0 && e1 <= 0 && e2 <= 0)
                            : (e0 >= 0 && e1 >= 0 && e2 >= 0);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      init_clr <= 1'b1;
      addr_cnt <= '0;
      done <= 1'b0;
      we <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done <= 1'b0;
      we <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          depth_value <= '0;
          x0 <= 18'(v0_x); y0 <= 18'(v0_y); x1 <= 18'(v1_x); y1 <= 18'(v1_y);
          x2 <= 18'(v2_x); y2 <= 18'(v2_y);
          z0 <= v0_z; z1 <= v1_z; z2 <= v2_z;
          minx <= (fl16(mnx) < 0) ? 14'sd0 : fl16(mnx);
          miny <= (fl16(mny) < 0) ? 14'sd0 : fl16(mny);
          // signed clip: an empty screen leaves max at -1
          maxx <= (ce_mxx > $signed(17'(eff_w)) - 17'sd1)
                  ? 14'($signed({1'b0, eff_w}) - 12'sd1) : 14'(ce_mxx);
          maxy <= (ce_mxy > $signed(17'(eff_h)) - 17'sd1)
                  ? 14'($signed({1'b0, eff_h}) - 12'sd1) : 14'(ce_mxy);
          step <= '0;
          addr_cnt <= '0;
          case (cmd)
            CmdDraw:  state <= S_SETUP;
            CmdClear: state <= S_CLEAR;
            CmdRead: begin
              rd_skip <= !rd_ok;
              px <= 14'(read_x);
              py <= 14'(read_y);
              state <= S_READ;
            end
            default: done <= 1'b1;
          endcase
        end
        S_CLEAR: begin
          we <= 1'b1; waddr <= addr_cnt; wdata <= DepthInf;
          addr_cnt <= addr_cnt + 1'b1;
          if (addr_cnt == AddrW'(Depth - 1)) begin
            state <= S_IDLE;
            done <= !init_clr;
            init_clr <= 1'b0;
          end
        end
        S_READ: begin
          step <= step + 4'd1;
          if (step == 4'd0) raddr <= idx;
          if (step == 4'd2) begin
            depth_value <= rd_skip ? DepthInf : rdata;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SETUP: begin
          if (step == 4'd0) begin
            t1 <= 37'(mp); step <= 4'd1;
          end else begin
            area <= t1 - 37'(mp);
            if (t1 == 37'(mp) || minx > maxx || miny > maxy) begin
              done <= 1'b1; state <= S_IDLE;
            end else begin
              px <= minx; py <= miny; step <= 4'd2; state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          step <= step + 4'd1;
          if (!step[0]) t1 <= 37'(mp);
          else begin
            case (step)
              4'd3: e0 <= t1 - 37'(mp);
              4'd5: e1 <= t1 - 37'(mp);
              default: e2 <= t1 - 37'(mp);
            endcase
            if (step == 4'd7) state <= S_TEST;
          end
        end
        S_TEST: begin
          step <= '0; acc <= '0;
          raddr <= idx;
          state <= covered ? S_ZMUL : S_NEXT;
        end
        S_ZMUL: begin
          acc <= acc + (step[0] ? {zp, 18'd0} : 64'(zp));
          step <= step + 4'd1;
          if (step == 4'd5) begin
            state <= S_DIV;
            div_go <= 1'b1;
          end
        end
        S_DIV: if (div_done) begin
          dnew <= (quo > 64'(DepthMaxv)) ? DepthMaxv : quo[23:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (dnew < rdata) begin
            we <= 1'b1; waddr <= raddr; wdata <= dnew;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          step <= 4'd2;
          if (px == maxx) begin
            px <= minx;
            if (py == maxy) begin
              done <= 1'b1; state <= S_IDLE;
            end else begin
              py <= py + 14'sd1; state <= S_MUL;
            end
          end else begin
            px <= px + 14'sd1; state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TDR_ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE)
  `TDR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy && cmd != CmdUnused, busy)
  `TDR_ASSERT_IMP(a_write_ok, clk, rst, we, state == S_CLEAR || state == S_NEXT || state == S_IDLE)
endmodule

/* tb/triangle_depth_rasterizer_top_tb.sv */
module triangle_depth_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdr_pkg::*;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] x0, y0, x1, y1, x2, y2;
    logic [23:0]        z0, z1, z2;
    logic signed [11:0] rx, ry;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] cmd = '0;
  logic signed [15:0] v0_x = '0, v0_y = '0, v1_x = '0, v1_y = '0, v2_x = '0, v2_y = '0;
  logic [23:0] v0_z = '0, v1_z = '0, v2_z = '0;
  logic signed [11:0] read_x = '0, read_y = '0;
  logic [23:0] depth_value;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  triangle_depth_rasterizer_top u_dut (.*);

  always #6 clk = ~clk;

  // Shadow of the block: depth store plus the two screen registers.
  logic [23:0] depth_mirror [Depth];
  logic [9:0]  scr_w = 10'd512, scr_h = 10'd512;

  req_t        pending_reqs[$];
  logic [23:0] depth_expected[$];
  req_t        cur;
  int          sender_idle_pct = 36;
  int          mismatches = 0, checked = 0;
  int          n_draw = 0, n_read = 0, n_clear = 0, n_phase = 0;

  function automatic longint eff_w();
    return (scr_w > MaxWidth) ? MaxWidth : longint'(scr_w);
  endfunction

  function automatic longint eff_h();
    return (scr_h > MaxHeight) ? MaxHeight : longint'(scr_h);
  endfunction

  function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
    return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic void fill_infinity();
    foreach (depth_mirror[i]) depth_mirror[i] = DepthInf;
  endfunction

  // Walk the clipped box, keep the nearer depth at each covered pixel centre.
  function automatic void rasterize(req_t r);
    longint x0, y0, x1, y1, x2, y2, w, h;
    longint minx, maxx, miny, maxy, area, e0, e1, e2, cx, cy;
    longint unsigned a0, a1, a2, ar, num, d;
    bit covered;
    x0 = r.x0; y0 = r.y0; x1 = r.x1; y1 = r.y1; x2 = r.x2; y2 = r.y2;
    w = eff_w(); h = eff_h();
    minx = min3(x0, x1, x2) >>> 4;
    miny = min3(y0, y1, y2) >>> 4;
    maxx = -((-max3(x0, x1, x2)) >>> 4);
    maxy = -((-max3(y0, y1, y2)) >>> 4);
    if (minx < 0) minx = 0;
    if (miny < 0) miny = 0;
    if (maxx > w - 1) maxx = w - 1;
    if (maxy > h - 1) maxy = h - 1;
    area = edge_fn(x0, y0, x1, y1, x2, y2);
    if (area == 0) return;
    ar = (area < 0) ? -area : area;
    for (longint py = miny; py <= maxy; py++) begin
      for (longint px = minx; px <= maxx; px++) begin
        cx = px * 16 + 8;
        cy = py * 16 + 8;
        e0 = edge_fn(x1, y1, x2, y2, cx, cy);
        e1 = edge_fn(x2, y2, x0, y0, cx, cy);
        e2 = edge_fn(x0, y0, x1, y1, cx, cy);
        // zero weight counts as inside, either winding
        if (area > 0) covered = (e0 >= 0) && (e1 >= 0) && (e2 >= 0);
        else covered = (e0 <= 0) && (e1 <= 0) && (e2 <= 0);
        if (covered) begin
          a0 = (e0 < 0) ? -e0 : e0;
          a1 = (e1 < 0) ? -e1 : e1;
          a2 = (e2 < 0) ? -e2 : e2;
          num = a0 * r.z0 + a1 * r.z1 + a2 * r.z2;
          d = num / ar;
          if (d > DepthMaxv) d = DepthMaxv;
          if (d[23:0] < depth_mirror[py * w + px]) depth_mirror[py * w + px] = d[23:0];
        end
      end
    end
  endfunction

  function automatic logic [23:0] depth_of_request(req_t r);
    longint rx, ry;
    case (r.cmd)
      CmdDraw: begin
        rasterize(r);
        n_draw++;
      end
      CmdClear: begin
        fill_infinity();
        n_clear++;
      end
      CmdRead: begin
        n_read++;
        rx = r.rx;
        ry = r.ry;
        if (rx < 0 || ry < 0 || rx >= eff_w() || ry >= eff_h()) return DepthInf;
        return depth_mirror[ry * eff_w() + rx];
      end
      default: ;
    endcase
    return '0;
  endfunction

  task automatic report(string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    mismatches++;
  endtask

  // Driver: a request is taken when start is high and busy low at the edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) depth_expected.push_back(depth_of_request(cur));
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur = pending_reqs.pop_front();
          cmd <= cur.cmd;
          v0_x <= cur.x0; v0_y <= cur.y0; v0_z <= cur.z0;
          v1_x <= cur.x1; v1_y <= cur.y1; v1_z <= cur.z1;
          v2_x <= cur.x2; v2_y <= cur.y2; v2_z <= cur.z2;
          read_x <= cur.rx; read_y <= cur.ry;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe carries one depth result.
  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst && done) begin
      if (depth_expected.size() == 0) begin
        report($sformatf("unexpected result depth=%06h", depth_value));
      end else begin
        want = depth_expected.pop_front();
        checked++;
        if (depth_value !== want)
          report($sformatf("depth_value got %06h want %06h", depth_value, want));
      end
    end
  end

  function automatic void add_draw(int x0, int y0, int z0, int x1, int y1, int z1,
                                   int x2, int y2, int z2);
    req_t r;
    r = '0;
    r.cmd = CmdDraw;
    r.x0 = 16'(x0); r.y0 = 16'(y0); r.z0 = 24'(z0);
    r.x1 = 16'(x1); r.y1 = 16'(y1); r.z1 = 24'(z1);
    r.x2 = 16'(x2); r.y2 = 16'(y2); r.z2 = 24'(z2);
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_read(int rx, int ry);
    req_t r;
    r = '0;
    r.cmd = CmdRead;
    r.rx = 12'(rx);
    r.ry = 12'(ry);
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_plain(logic [1:0] c);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.cmd = c;
    pending_reqs.push_back(r);
  endfunction

  // Mostly small triangles on screen and reads around them; noise uses raw fields.
  function automatic void add_random(int n, bit noise_ok);
    int w, h, bx, by, sel;
    w = (eff_w() > 0) ? int'(eff_w()) : 1;
    h = (eff_h() > 0) ? int'(eff_h()) : 1;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      bx = $urandom_range(w - 1) * 16 + $urandom_range(15);
      by = $urandom_range(h - 1) * 16 + $urandom_range(15);
      if (sel < 45) begin
        add_draw(bx + $urandom_range(160) - 80, by + $urandom_range(160) - 80, $urandom,
                 bx + $urandom_range(160) - 80, by + $urandom_range(160) - 80, $urandom,
                 bx + $urandom_range(160) - 80, by + $urandom_range(160) - 80, $urandom);
      end else if (sel < 85) begin
        add_read(bx / 16 + $urandom_range(4) - 2, by / 16 + $urandom_range(4) - 2);
      end else if (sel < 90) begin
        add_plain(CmdUnused);
      end else if (noise_ok) begin
        add_plain(sel < 95 ? CmdDraw : CmdRead);
      end else begin
        add_read($urandom_range(4095) - 2048, $urandom_range(4095) - 2048);
      end
    end
  endfunction

  task automatic drain();
    @(posedge clk);
    #1;
    while (pending_reqs.size() > 0 || start || busy || depth_expected.size() > 0) begin
      @(posedge clk);
      #1;
    end
    repeat (8) @(posedge clk);
  endtask

  // Registers change only with the block idle and no result outstanding.
  task automatic set_screen(logic [9:0] w, logic [9:0] h, int idle_pct);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= RegWidth;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= RegHeight;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    sender_idle_pct = idle_pct;
    n_phase++;
    #1;
  endtask

  initial begin
    fill_infinity();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed at the reset screen of 512x512; edges run through pixel centres.
    add_read(0, 0);
    add_draw(8, 8, 24'h000000, 136, 8, 24'hFFFFFF, 8, 136, 24'h123456);
    add_draw(8, 8, 24'hFFFFFF, 8, 136, 24'hFFFFFF, 136, 8, 24'hFFFFFF);
    add_draw(0, 0, 24'h0, 64, 64, 24'h0, 128, 128, 24'h0);        // zero area
    add_draw(-40, -40, 24'h800000, 60, -8, 24'h800000, -8, 90, 24'h800000);
    add_read(0, 0); add_read(1, 0); add_read(3, 3); add_read(8, 0); add_read(0, 8);
    add_read(-1, 0); add_read(0, -1); add_read(511, 511); add_read(512, 0);
    add_read(0, 512); add_read(-2048, -2048); add_read(2047, 2047);
    add_plain(CmdUnused);
    add_plain(CmdClear);
    add_read(0, 0);
    add_read(1, 1);
    add_draw(8, 8, 24'hFFFFFF, 72, 8, 24'hFFFFFF, 8, 72, 24'hFFFFFF);
    add_read(1, 1);

    // Register above the maximum saturates to 512.
    set_screen(10'd1023, 10'd1023, 36);
    add_random(20, 1'b0);

    // Zero width: nothing lands, every read is infinity.
    set_screen(10'd0, 10'd5, 45);
    add_draw(-32768, -32768, 24'h0, 32767, -32768, 24'h0, -32768, 32767, 24'h0);
    add_read(0, 0);
    add_random(6, 1'b0);

    // Tiny screen lets full-range coordinates through without long walks.
    set_screen(10'd8, 10'd8, 45);
    add_draw(-32768, -32768, 24'h000001, 32767, -32768, 24'hFFFFFE, -32768, 32767, 24'h0);
    add_draw(32767, 32767, 24'h0, -32768, 32767, 24'h0, 32767, -32768, 24'h0);
    add_read(7, 7); add_read(8, 7); add_read(7, 8);
    add_random(25, 1'b1);

    set_screen(10'd1, 10'd1, 45);
    add_random(10, 1'b1);

    // Odd sizes change the row stride; one clear midway.
    set_screen(10'd37, 10'd23, 0);
    add_random(20, 1'b0);
    add_plain(CmdClear);
    add_random(20, 1'b0);

    set_screen(10'd512, 10'd512, 0);
    add_random(10, 1'b0);

    drain();
    $display("Covered %0d draws, %0d reads, %0d clears over %0d screen settings.",
             n_draw, n_read, n_clear, n_phase + 1);
    $display("%0d depth results compared, %0d mismatches.", checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d results outstanding.", depth_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
